FILE: sv/eiq_pkg.sv
// ---------------------------------------------------------------------------
// eiq_pkg
// Shared constants and types for the elliptic integral quadrature block.
// ---------------------------------------------------------------------------
package eiq_pkg;

    localparam int MAX_INTERVALS = 64;

    localparam logic [31:0] Q_ONE     = 32'h4000_0000;
    localparam logic [31:0] Q_PI      = 32'd3373259426;
    localparam logic [31:0] Q_HALF_PI = 32'd1686629713;
    localparam logic [19:0] OUT_MAX   = 20'hFFFFF;

    localparam logic [0:0] REG_RULE  = 1'b0;
    localparam logic [0:0] REG_COUNT = 1'b1;

    // Horner divisors for the sine series
    function automatic logic [7:0] horner_div(input logic [2:0] j);
        case (j)
            3'd0:    horner_div = 8'd156;
            3'd1:    horner_div = 8'd110;
            3'd2:    horner_div = 8'd72;
            3'd3:    horner_div = 8'd42;
            3'd4:    horner_div = 8'd20;
            default: horner_div = 8'd6;
        endcase
    endfunction

    // Request to the serial divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [33:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

FILE: sv/eiq_div.sv
// ---------------------------------------------------------------------------
// eiq_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module eiq_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  eiq_pkg::t_div_req i_req,
    output eiq_pkg::t_div_rsp o_rsp
);
    import eiq_pkg::*;

    logic [63:0] r_quo;
    logic [34:0] r_rem;
    logic [33:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [34:0] w_trial;
    logic [34:0] w_diff;

    assign w_trial = {r_rem[33:0], r_quo[63]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                // one quotient bit a cycle
                if (!w_diff[34]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: sv/eiq_sqrt.sv
// ---------------------------------------------------------------------------
// eiq_sqrt
// Digit-serial floor square root of a 62-bit value, two radicand bits a cycle.
// ---------------------------------------------------------------------------
module eiq_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [61:0] i_val,
    output logic        o_done,
    output logic [30:0] o_root
);
    import eiq_pkg::*;

    logic [61:0] r_val;
    logic [32:0] r_rem;
    logic [30:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [32:0] w_trial;
    logic [32:0] w_sub;
    logic [32:0] w_diff;

    assign w_trial = {r_rem[30:0], r_val[61:60]};
    assign w_sub   = {r_root, 2'b01};
    assign w_diff  = w_trial - w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                // one root bit a cycle
                r_val <= {r_val[59:0], 2'b00};
                if (w_trial >= w_sub) begin
                    r_rem  <= w_diff;
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_root <= {r_root[29:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: sv/elliptic_integral_quadrature.sv
// ---------------------------------------------------------------------------
// elliptic_integral_quadrature
// Pendulum period ratio by trapezoid or Simpson quadrature of K(k).
// ---------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)        | tuser
// s_axis  | in  | amplitude[17:0]                  | -
// m_axis  | out | period_ratio[19:0]               | saturated
// apb     | in  | 0x0 rule_select, 0x4 interval_count
//
// Nearly all of an item's time goes to the shared serial divider: six
// divisions for each sine (the amplitude and every node), one for each
// node angle, one for each reciprocal and one for the final scaling. The
// square root unit runs once per node.
// Reset is synchronous; registers return to Simpson with four intervals.
// A finished result waits in the output register; a new item is taken only
// once the previous result has left.
// ---------------------------------------------------------------------------
module elliptic_integral_quadrature (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // amplitude[17:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // period_ratio[19:0]
    output logic        m_axis_tuser,   // saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import eiq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_K_SIN, S_K_SQ, S_NODE, S_PHI_WAIT, S_SIN, S_SIN_X2,
        S_HMUL, S_HDIV, S_HWAIT, S_SMUL, S_S2, S_U, S_SQRT, S_SQRT_WAIT,
        S_RECIP, S_RECIP_WAIT, S_ACC, S_FIN, S_FIN_WAIT, S_OUT
    } t_state;

    t_state      r_state;
    logic        r_rule;
    logic [6:0]  r_count;
    logic        r_simp;
    logic [6:0]  r_n;
    logic [6:0]  r_i;
    logic [31:0] r_x;
    logic [31:0] r_x2;
    logic [31:0] r_t;
    logic [2:0]  r_j;
    logic        r_kphase;
    logic [31:0] r_k2;
    logic [31:0] r_s;
    logic [63:0] r_prod;
    logic [63:0] r_sum;
    logic        r_sat;
    logic [19:0] r_res;
    logic        r_ovalid;

    t_div_req w_req;
    t_div_rsp w_rsp;
    logic        w_sq_start;
    logic [61:0] w_sq_val;
    logic        w_sq_done;
    logic [30:0] w_sq_root;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [31:0] w_sinx;
    logic [31:0] w_pr30;
    logic [31:0] w_d;
    logic [2:0]  w_wt;
    logic [15:0] w_den_sc;
    logic [63:0] w_fw;

    eiq_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));
    eiq_sqrt u_sqrt (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_sq_start),
                     .i_val(w_sq_val), .o_done(w_sq_done), .o_root(w_sq_root));

    // APB: always ready, reads return the register
    assign pready = 1'b1;
    always_comb begin
        case (paddr[2])
            REG_RULE:  prdata = {31'd0, r_rule};
            REG_COUNT: prdata = {25'd0, r_count};
            default:   prdata = '0;
        endcase
    end

    // shared 32x32 multiplier, product registered into r_prod
    always_comb begin
        case (r_state)
            S_SIN_X2: begin w_mul_a = r_x;  w_mul_b = r_x;  end
            S_HMUL:   begin w_mul_a = r_x2; w_mul_b = r_t;  end
            S_SMUL:   begin w_mul_a = r_x;  w_mul_b = r_t;  end
            S_K_SQ, S_S2: begin w_mul_a = r_s; w_mul_b = r_s; end
            S_U:      begin w_mul_a = r_k2; w_mul_b = r_s;  end
            default:  begin w_mul_a = r_x;  w_mul_b = r_t;  end
        endcase
    end

    assign w_pr30  = r_prod[61:30];
    assign w_sinx  = (r_x > Q_PI) ? Q_PI : r_x;
    assign w_d     = Q_ONE - w_pr30;
    assign w_den_sc = r_simp ? ({9'd0, r_n} * 16'd3) : {8'd0, r_n, 1'b0};

    always_comb begin
        if (r_i == 7'd0 || r_i == r_n) w_wt = 3'd1;
        else if (r_simp && r_i[0])     w_wt = 3'd4;
        else                           w_wt = 3'd2;
    end

    // weighted integrand: weights are 1, 2 or 4, so a shift
    always_comb begin
        case (w_wt)
            3'd4:    w_fw = {w_rsp.quo[61:0], 2'b00};
            3'd2:    w_fw = {w_rsp.quo[62:0], 1'b0};
            default: w_fw = w_rsp.quo;
        endcase
    end

    // divider requests
    always_comb begin
        w_req = '0;
        case (r_state)
            S_NODE: begin
                w_req.start = 1'b1;
                w_req.num   = {25'd0, r_i} * {32'd0, Q_HALF_PI};
                w_req.den   = {27'd0, r_n};
            end
            S_HDIV: begin
                w_req.start = 1'b1;
                w_req.num   = {32'd0, w_pr30};
                w_req.den   = {26'd0, horner_div(r_j)};
            end
            S_RECIP: begin
                w_req.start = 1'b1;
                w_req.num   = 64'h1000_0000_0000_0000;
                w_req.den   = {3'd0, w_sq_root};
            end
            S_FIN: begin
                w_req.start = 1'b1;
                w_req.num   = r_sum + {34'd0, w_den_sc, 14'd0} / 2;
                w_req.den   = {4'd0, w_den_sc, 14'd0};
            end
            default: w_req = '0;
        endcase
    end

    assign w_sq_start = (r_state == S_SQRT);
    assign w_sq_val   = {w_d[31:0], 30'd0};

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_res};
    assign m_axis_tuser  = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rule   <= 1'b1;
            r_count  <= 7'd4;
            r_ovalid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'd0) r_rule  <= pwdata[0];
                if (paddr == 3'd4) r_count <= pwdata[6:0];
            end
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_x      <= {1'b0, s_axis_tdata[17:0], 13'd0};
                    r_kphase <= 1'b1;
                    r_sum    <= '0;
                    r_sat    <= 1'b0;
                    r_i      <= '0;
                    r_simp   <= r_rule;
                    if (r_count < 7'd2)
                        r_n <= 7'd2;
                    else if (r_count > 7'd64)
                        r_n <= r_rule ? 7'd64 : 7'd64;
                    else
                        r_n <= r_rule ? {r_count[6:1], 1'b0} : r_count;
                    r_state <= S_SIN;
                end
                S_NODE:     r_state <= S_PHI_WAIT;
                S_PHI_WAIT: if (w_rsp.done) begin
                    r_x <= w_rsp.quo[31:0];
                    r_state <= S_SIN;
                end
                // range reduction then x^2
                S_SIN: begin
                    r_x <= (w_sinx > Q_HALF_PI) ? Q_PI - w_sinx : w_sinx;
                    r_t <= Q_ONE;
                    r_j <= 3'd0;
                    r_state <= S_SIN_X2;
                end
                S_SIN_X2: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_state <= S_K_SIN;
                end
                S_K_SIN: begin
                    r_x2 <= w_pr30;
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_state <= S_HDIV;
                end
                S_HDIV: r_state <= S_HWAIT;
                S_HWAIT: if (w_rsp.done) begin
                    r_t <= Q_ONE - w_rsp.quo[31:0];
                    r_j <= r_j + 3'd1;
                    r_state <= (r_j == 3'd5) ? S_SMUL : S_HMUL;
                end
                S_SMUL: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_state <= S_S2;
                end
                S_S2: begin
                    r_s <= (w_pr30 > Q_ONE) ? Q_ONE : w_pr30;
                    r_state <= S_K_SQ;
                end
                // square of the sine, then k2 or u
                S_K_SQ: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_state <= r_kphase ? S_ACC : S_OUT;
                end
                S_OUT: begin
                    r_s <= w_pr30;
                    r_state <= S_U;
                end
                S_U: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_pr30 >= Q_ONE) begin
                        r_sat <= 1'b1;
                        r_res <= OUT_MAX;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_state <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT: if (w_sq_done) begin
                    if (w_sq_root == '0) begin
                        r_sat <= 1'b1;
                        r_res <= OUT_MAX;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end else r_state <= S_RECIP;
                end
                S_RECIP: r_state <= S_RECIP_WAIT;
                S_RECIP_WAIT: if (w_rsp.done) begin
                    r_sum <= r_sum + w_fw;
                    if (r_i == r_n) r_state <= S_FIN;
                    else begin
                        r_i <= r_i + 7'd1;
                        r_state <= S_NODE;
                    end
                end
                // k phase done: keep k2, start node 0
                S_ACC: begin
                    r_k2 <= w_pr30;
                    r_kphase <= 1'b0;
                    r_state <= S_NODE;
                end
                S_FIN: r_state <= S_FIN_WAIT;
                S_FIN_WAIT: if (w_rsp.done) begin
                    if (w_rsp.quo > {44'd0, OUT_MAX}) begin
                        r_res <= OUT_MAX;
                        r_sat <= 1'b1;
                    end else r_res <= w_rsp.quo[19:0];
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/eiq_checker.sv
// ---------------------------------------------------------------------------
// eiq_checker
// Port-level checks on the quadrature block.
// ---------------------------------------------------------------------------
module eiq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        pready
);
    // no new item while a result waits
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while busy");
    // saturated results carry the maximum
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[19:0] == 20'hFFFFF))
        else $error("saturation value");
    // accepted item gives no result next cycle
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("too fast");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
endmodule

bind elliptic_integral_quadrature eiq_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .pready(pready));

FILE: tb/tb_elliptic_integral_quadrature.sv
// ---------------------------------------------------------------------------
// tb_elliptic_integral_quadrature
// Self-checking bench for the pendulum period ratio block. Amplitudes are
// streamed in under several rule and interval settings. A bit-true predictor
// of the fixed point quadrature works out each period ratio and its
// saturation flag. Results are checked in order, field by field.
// ---------------------------------------------------------------------------
module tb_elliptic_integral_quadrature;
    timeunit 1ns;
    timeprecision 1ps;

    import eiq_pkg::*;

    localparam int          CYCLE_LIMIT = 8_000_000;
    localparam logic [2:0]  ADDR_RULE   = {REG_RULE, 2'b00};
    localparam logic [2:0]  ADDR_COUNT  = {REG_COUNT, 2'b00};
    localparam logic [17:0] AMP_PI      = 18'd205887;

    typedef struct {
        logic [19:0] ratio;
        logic        sat;
    } t_ratio;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // amplitude[17:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;    // period_ratio[19:0]
    logic        m_axis_tuser;    // saturated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    elliptic_integral_quadrature DUT (.*);

    // Bench copy of the registers
    logic        rule_simpson;
    logic [6:0]  count_reg;

    logic [17:0] amp_pending[$];
    t_ratio      ratio_expected[$];
    int          mismatches;
    int          cycles;
    bit          idle_on;
    bit          hold_req;
    bit          in_taken;
    int          gap_left;
    int          stall_left;
    int          hold_left;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Truncating Q30 sine, folded about pi/2
    function automatic logic [63:0] q30_sine(input logic [63:0] xin);
        logic [63:0] x, x2, t, s;
        logic [63:0] divs[6];
        divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x = xin;
        if (x > 64'(Q_PI)) x = 64'(Q_PI);
        if (x > 64'(Q_HALF_PI)) x = 64'(Q_PI) - x;
        x2 = (x * x) >> 30;
        t = 64'(Q_ONE);
        for (int j = 0; j < 6; j++)
            t = 64'(Q_ONE) - ((x2 * t) >> 30) / divs[j];
        s = (x * t) >> 30;
        return (s > 64'(Q_ONE)) ? 64'(Q_ONE) : s;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
        logic [63:0] v, r, b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Period ratio of one amplitude under the current registers
    function automatic t_ratio predict_ratio(input logic [17:0] amp);
        t_ratio      res;
        logic [63:0] k, k2, n, phi, s, s2, u, q, f, w, total, den, r;
        bit          sat;
        k     = q30_sine(64'(amp) << 13);
        k2    = (k * k) >> 30;
        n     = 64'(count_reg);
        sat   = 1'b0;
        total = 64'd0;
        if (n < 64'd2) n = 64'd2;
        if (n > 64'(MAX_INTERVALS)) n = 64'(MAX_INTERVALS);
        if (rule_simpson) n[0] = 1'b0;
        for (logic [63:0] i = 0; i <= n; i++) begin
            phi = (i * 64'(Q_HALF_PI)) / n;
            s   = q30_sine(phi);
            s2  = (s * s) >> 30;
            u   = (k2 * s2) >> 30;
            if (u >= 64'(Q_ONE)) begin
                sat = 1'b1;
                break;
            end
            q = floor_sqrt((64'(Q_ONE) - u) << 30);
            if (q == 0) begin
                sat = 1'b1;
                break;
            end
            f = (64'd1 << 60) / q;
            if (i == 0 || i == n) w = 64'd1;
            else if (rule_simpson) w = i[0] ? 64'd4 : 64'd2;
            else w = 64'd2;
            total += w * f;
        end
        if (sat) begin
            r = 64'(OUT_MAX);
        end else begin
            den = ((rule_simpson ? 64'd3 : 64'd2) * n) << 14;
            r = (total + den / 2) / den;
            if (r > 64'(OUT_MAX)) begin
                r = 64'(OUT_MAX);
                sat = 1'b1;
            end
        end
        res.ratio = r[19:0];
        res.sat   = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Input driver: sender gaps come in bursts
    always @(negedge i_clk) begin
        logic        nv;
        logic [23:0] nd;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            nv = 1'b0;
            if (in_taken && idle_on && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 18);
            if (gap_left > 0) begin
                gap_left--;
            end else if (amp_pending.size() > 0) begin
                nv = 1'b1;
                nd = {6'd0, amp_pending.pop_front()};
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata  <= nd;
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        logic nr;
        nr = 1'b1;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 12000;
        end
        if (hold_left > 0) begin
            hold_left--;
            nr = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            nr = 1'b0;
        end
        m_axis_tready <= nr;
    end

    // Monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_ratio want;
        in_taken = 1'b0;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                ratio_expected.push_back(predict_ratio(s_axis_tdata[17:0]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (ratio_expected.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[19:0], -1);
                end else begin
                    want = ratio_expected.pop_front();
                    if (m_axis_tdata[19:0] !== want.ratio)
                        report_mismatch("period_ratio", m_axis_tdata[19:0], want.ratio);
                    if (m_axis_tuser !== want.sat)
                        report_mismatch("saturated", m_axis_tuser, want.sat);
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RULE) rule_simpson = val[0];
        else if (addr == ADDR_COUNT) count_reg = val[6:0];
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (amp_pending.size() > 0 || s_axis_tvalid || ratio_expected.size() > 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [17:0] random_amplitude();
        if ($urandom_range(0, 3) == 0)
            return AMP_PI - 18'd150 + 18'($urandom_range(0, 300));
        return 18'($urandom_range(0, 262143));
    endfunction

    // One setting: program both registers, then stream amplitudes
    task automatic run_setting(input logic rule, input logic [6:0] cnt, input int items);
        reg_write(ADDR_RULE, {31'($urandom) , rule});
        reg_write(ADDR_COUNT, {25'($urandom), cnt});
        for (int i = 0; i < items; i++)
            amp_pending.push_back(random_amplitude());
        wait_drained();
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rule_simpson  = 1'b1;
        count_reg     = 7'd4;
        mismatches    = 0;
        cycles        = 0;
        idle_on       = 1'b1;
        hold_req      = 1'b0;
        gap_left      = 0;
        stall_left    = 0;
        hold_left     = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed amplitudes under the reset registers: extremes, single
        // bits, around pi where the integrand blows up, above pi
        amp_pending.push_back(18'd0);
        amp_pending.push_back(18'd1);
        amp_pending.push_back(18'h3FFFF);
        for (int b = 2; b < 18; b += 2)
            amp_pending.push_back(18'd1 << b);
        amp_pending.push_back(18'h2AAAA);
        amp_pending.push_back(18'h15555);
        amp_pending.push_back(AMP_PI - 18'd2000);
        amp_pending.push_back(AMP_PI - 18'd20);
        amp_pending.push_back(AMP_PI);
        amp_pending.push_back(AMP_PI + 18'd1);
        amp_pending.push_back(AMP_PI + 18'd500);
        amp_pending.push_back(18'd240000);
        wait_drained();

        // Long receiver hold-off while items keep coming
        hold_req = 1'b1;
        run_setting(1'b0, 7'd2, 40);
        run_setting(1'b1, 7'd2, 70);
        run_setting(1'b0, 7'd3, 60);
        run_setting(1'b1, 7'd3, 60);   // odd count under Simpson
        run_setting(1'b0, 7'd0, 50);   // below range
        run_setting(1'b1, 7'd1, 50);
        run_setting(1'b0, 7'd127, 3);  // clamps to the maximum
        run_setting(1'b1, 7'd64, 3);
        run_setting(1'b1, 7'd65, 2);
        run_setting(1'b0, 7'd5, 60);
        run_setting(1'b1, 7'd6, 50);
        run_setting(1'b0, 7'd4, 60);
        idle_on = 1'b0;
        run_setting(1'b1, 7'd4, 60);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
